FILE: src/generational_slot_allocator_defines.svh
// Assertion macros used by the slot allocator checker.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gsa_pkg.sv
// Types and constants of the generational slot allocator.
package gsa_pkg;

  localparam int SLOT_COUNT_DEFAULT = 64;
  localparam int GEN_W = 32;
  localparam int HSLOT_W = 8;
  localparam int GSLOT_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_FIND    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [HSLOT_W-1:0] handle_slot;
    logic [GEN_W-1:0]   handle_generation;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [GSLOT_W-1:0] granted_slot;
    logic [GEN_W-1:0]   granted_generation;
    logic [COUNT_W-1:0] busy_count;
  } out_word_t;

endpackage

FILE: src/generational_slot_allocator.sv
// Generational slot allocator: busy flags in flops, generations in a RAM.
// An accepted word is taken to S_READ, whose result goes to out_word or waits in S_HOLD.
// No new word is taken before S_IDLE; the generation RAM read precedes the update.
// A waiting result does not block the next accept; a second result waits for the first.
// Synchronous reset frees every slot and marks every generation as 1 at once.
// There is no clearing pass; the block is ready in the first cycle after reset.
module generational_slot_allocator #(
  parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gsa_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output gsa_pkg::out_word_t out_word
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_HOLD} state_t;

  state_t                      state;
  logic [SLOT_COUNT-1:0]       busy;
  logic [SLOT_COUNT-1:0]       gen_valid;
  logic [gsa_pkg::COUNT_W-1:0] busy_total;
  logic [gsa_pkg::COUNT_W-1:0] busy_total_next;
  logic [1:0]                  kind;
  logic [gsa_pkg::GEN_W-1:0]   gen_req;
  logic [IDX_W-1:0]            addr;
  logic                        in_range;
  logic                        found;
  gsa_pkg::out_word_t          res;
  gsa_pkg::out_word_t          res_next;

  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic [IDX_W-1:0]            addr_next;
  logic                        in_range_next;
  logic [gsa_pkg::GEN_W-1:0]   ram_q;
  logic [gsa_pkg::GEN_W-1:0]   gen_cur;
  logic [gsa_pkg::GEN_W-1:0]   gen_inc;
  logic                        match;
  logic                        we;
  logic                        set_busy;
  logic                        clr_busy;
  logic                        load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = ((state == S_READ) || (state == S_HOLD)) && (!out_valid || out_ready);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign in_range_next = ({1'b0, in_word.handle_slot} < (gsa_pkg::HSLOT_W + 1)'(SLOT_COUNT));
  assign addr_next = (in_word.kind == gsa_pkg::KIND_ACQUIRE) ? free_idx
                                                             : in_word.handle_slot[IDX_W-1:0];

  gsa_ram #(
    .WIDTH(gsa_pkg::GEN_W),
    .DEPTH(SLOT_COUNT)
  ) u_gen_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(gen_inc),
    .raddr(addr_next),
    .rdata(ram_q)
  );

  assign gen_cur = gen_valid[addr] ? ram_q : gsa_pkg::GEN_W'(1);
  assign gen_inc = (gen_cur == '1) ? gsa_pkg::GEN_W'(1) : gen_cur + gsa_pkg::GEN_W'(1);
  assign match   = in_range && (gen_cur == gen_req);

  always_comb begin
    res_next        = '0;
    set_busy        = 1'b0;
    clr_busy        = 1'b0;
    we              = 1'b0;
    busy_total_next = busy_total;
    if (state == S_READ) begin
      case (kind)
        gsa_pkg::KIND_ACQUIRE: begin
          if (found) begin
            set_busy                    = 1'b1;
            busy_total_next             = busy_total + gsa_pkg::COUNT_W'(1);
            res_next.ok                 = 1'b1;
            res_next.granted_slot       = gsa_pkg::GSLOT_W'(addr);
            res_next.granted_generation = gen_cur;
          end
        end
        gsa_pkg::KIND_RELEASE: begin
          if (match) begin
            we          = 1'b1;
            res_next.ok = 1'b1;
            if (busy[addr]) begin
              clr_busy        = 1'b1;
              busy_total_next = busy_total - gsa_pkg::COUNT_W'(1);
            end
          end
        end
        gsa_pkg::KIND_FIND: begin
          res_next.ok = match;
        end
        default: begin
          res_next.ok = 1'b0;
        end
      endcase
    end
    res_next.busy_count = busy_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      busy       <= '0;
      gen_valid  <= '0;
      busy_total <= '0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind     <= in_word.kind;
            gen_req  <= in_word.handle_generation;
            addr     <= addr_next;
            in_range <= in_range_next;
            found    <= free_found;
            state    <= S_READ;
          end
        end
        S_READ: begin
          busy_total <= busy_total_next;
          if (set_busy) begin
            busy[addr] <= 1'b1;
          end
          if (clr_busy) begin
            busy[addr] <= 1'b0;
          end
          if (we) begin
            gen_valid[addr] <= 1'b1;
          end
          if (load_out) begin
            out_word  <= res_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            res   <= res_next;
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            out_word  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/gsa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module gsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gsa_checker.sv
// Port-level assertions for the generational slot allocator, with its bind.
`include "generational_slot_allocator_defines.svh"

module gsa_checker #(
  parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input gsa_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input gsa_pkg::out_word_t out_word
);

  `GSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")
  `GSA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word accepted while one is in work")
  `GSA_ASSERT_SAME(a_fail_is_zero, out_valid && !out_word.ok, (out_word.granted_slot == '0) && (out_word.granted_generation == '0), "failed result carries a grant")
  `GSA_ASSERT_SAME(a_count_bound, out_valid, (SLOT_COUNT >= 128) || (int'(out_word.busy_count) <= SLOT_COUNT), "busy count exceeds the pool size")

endmodule

bind generational_slot_allocator gsa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_gsa_checker (.*);
